// ----- hw/rtl/triangle_unit_normal_defines.svh -----
// Assertion macros for the triangle unit normal block.
// No dependencies; included by the RTL files that carry assertions.
`ifndef TRIANGLE_UNIT_NORMAL_DEFINES_SVH
`define TRIANGLE_UNIT_NORMAL_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TUN_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define TUN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define TUN_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TUN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/tun_pkg.sv -----
// Shared constants and types for the triangle unit normal block.
// No dependencies.
package tun_pkg;
	localparam int COORD_BITS_DEF       = 24;
	localparam int NORMAL_FRAC_BITS_DEF = 14;
	localparam int OUT_BITS             = 16;
	// scaled cross product magnitudes sit below 2^30; the largest of a non-degenerate triangle sits in [2^29, 2^30)
	localparam int M_BITS               = 30;
	localparam int S_BITS               = 2 * M_BITS + 2;
	localparam int R_BITS               = S_BITS / 2;
	localparam int D_BITS               = R_BITS + 1;

	typedef struct packed {
		logic [2:0][M_BITS-1:0] m;
		logic [2:0]             neg;
		logic                   deg;
	} tun_pass_t;

	typedef struct packed {
		logic [2:0] neg;
		logic       deg;
	} tun_flags_t;
endpackage

// ----- hw/rtl/tun_if.sv -----
// Channel interfaces of the triangle unit normal block.
// Depends on tun_pkg for default widths.
interface tun_in_if #(parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF) ();
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z;
	logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z;
	logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z;

	modport source (output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		input ready);
	modport sink (input valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
		output ready);
endinterface

interface tun_out_if ();
	logic                                valid;
	logic                                ready;
	logic signed [tun_pkg::OUT_BITS-1:0] normal_x, normal_y, normal_z;
	logic                                degenerate;

	modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
	modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

// ----- hw/rtl/tun_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, floor result.
// Depends on tun_pkg.
module tun_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  logic [tun_pkg::S_BITS-1:0] rad,
	input  tun_pkg::tun_pass_t in_pass,
	output logic               out_valid,
	output logic [tun_pkg::R_BITS-1:0] root,
	output tun_pkg::tun_pass_t out_pass
);
	import tun_pkg::*;

	localparam int RMW = R_BITS + 2;
	localparam int TW  = RMW + 2;

	logic              vld_s  [R_BITS+1];
	logic [RMW-1:0]    rem_s  [R_BITS+1];
	logic [R_BITS-1:0] root_s [R_BITS+1];
	logic [S_BITS-1:0] rad_s  [R_BITS+1];
	tun_pass_t         pass_s [R_BITS+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = rad;
	assign pass_s[0] = in_pass;

	for (genvar k = 0; k < R_BITS; k++) begin : g_stage
		logic [TW-1:0]     t_rem, t_sub, n_rem;
		logic              ge;

		always_comb begin
			t_rem = TW'({rem_s[k], rad_s[k][S_BITS-1:S_BITS-2]});
			t_sub = TW'({root_s[k], 2'b01});
			ge    = t_rem >= t_sub;
			n_rem = ge ? t_rem - t_sub : t_rem;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= n_rem[RMW-1:0];
				root_s[k+1] <= {root_s[k][R_BITS-2:0], ge};
				rad_s[k+1]  <= rad_s[k] << 2;
				pass_s[k+1] <= pass_s[k];
			end
		end
	end

	assign out_valid = vld_s[R_BITS];
	assign root      = root_s[R_BITS];
	assign out_pass  = pass_s[R_BITS];
endmodule

// ----- hw/rtl/tun_div.sv -----
// Pipelined restoring divider, three lanes sharing one divisor, one quotient
// bit per stage. Depends on tun_pkg.
module tun_div #(
	parameter int QW = tun_pkg::NORMAL_FRAC_BITS_DEF + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [2:0][tun_pkg::D_BITS-1:0] rem0,
	input  logic [2:0][QW-1:0]            lo,
	input  logic [tun_pkg::D_BITS-1:0]    dvsr,
	input  tun_pkg::tun_flags_t           in_flags,
	output logic                          out_valid,
	output logic [2:0][QW-1:0]            quot,
	output tun_pkg::tun_flags_t           out_flags
);
	import tun_pkg::*;

	logic                      vld_s  [QW+1];
	logic [2:0][D_BITS-1:0]    rem_s  [QW+1];
	logic [2:0][QW-1:0]        lo_s   [QW+1];
	logic [2:0][QW-1:0]        quot_s [QW+1];
	logic [D_BITS-1:0]         dvsr_s [QW+1];
	tun_flags_t                flg_s  [QW+1];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = rem0;
	assign lo_s[0]   = lo;
	assign quot_s[0] = '0;
	assign dvsr_s[0] = dvsr;
	assign flg_s[0]  = in_flags;

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [2:0][D_BITS-1:0] n_rem;
		logic [2:0]             ge;

		always_comb begin
			logic [D_BITS:0] r;
			for (int i = 0; i < 3; i++) begin
				r        = {rem_s[j][i], lo_s[j][i][QW-1]};
				ge[i]    = r >= {1'b0, dvsr_s[j]};
				n_rem[i] = ge[i] ? D_BITS'(r - {1'b0, dvsr_s[j]}) : r[D_BITS-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					rem_s[j+1][i]  <= n_rem[i];
					lo_s[j+1][i]   <= lo_s[j][i] << 1;
					quot_s[j+1][i] <= {quot_s[j][i][QW-2:0], ge[i]};
				end
				dvsr_s[j+1] <= dvsr_s[j];
				flg_s[j+1]  <= flg_s[j];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quot      = quot_s[QW];
	assign out_flags = flg_s[QW];
endmodule

// ----- hw/rtl/triangle_unit_normal.sv -----
// Unit face normal of a triangle: edges, cross product, scaling, root, divide.
// Depends on tun_pkg, tun_if, tun_isqrt, tun_div and the defines header.
//
//   channel  role    payload
//   vert     sink    v0_x..v2_z, COORD_BITS signed each
//   norm     source  normal_x/y/z 16 bit signed Q1.14, degenerate
//
// One triangle per cycle while the output is not stalled; the pipeline depth is set by
// the 31-stage root pipeline and the one-bit-per-stage divider.
// All stages advance together whenever the output register is empty or taken.
// Reset clears only the valid bits; no clearing pass is needed.
`include "triangle_unit_normal_defines.svh"

module triangle_unit_normal #(
	parameter int COORD_BITS       = tun_pkg::COORD_BITS_DEF,
	parameter int NORMAL_FRAC_BITS = tun_pkg::NORMAL_FRAC_BITS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tun_in_if.sink    vert,
	tun_out_if.source norm
);
	import tun_pkg::*;

	localparam int EW = COORD_BITS + 1;
	localparam int PW = 2 * EW;
	localparam int DW = PW + 1;
	localparam int NG = (DW + 7) / 8;
	localparam int LW = $clog2(DW + 1);
	localparam int QW = NORMAL_FRAC_BITS + 1;
	localparam int NW = M_BITS + QW + 1;
	localparam int XW = (QW + 1 > OUT_BITS + 1) ? QW + 1 : OUT_BITS + 1;
	localparam logic signed [XW-1:0] SAT_HI = XW'(32767);
	localparam logic signed [XW-1:0] SAT_LO = -XW'(32768);
	localparam logic [QW-1:0] Q_MAX = QW'(1) << NORMAL_FRAC_BITS;

	logic en;

	// stage 1: edges
	logic signed [COORD_BITS-1:0] va [3], vb [3], vc [3];
	logic                 v_s1;
	logic signed [EW-1:0] e1_s1 [3], e2_s1 [3];

	// stage 2: products
	logic                 v_s2;
	logic signed [PW-1:0] p_s2 [3], q_s2 [3];

	// stage 3: cross product
	logic                 v_s3;
	logic signed [DW-1:0] c_s3 [3];

	// stage 4: magnitudes
	logic                 v_s4;
	logic [DW-1:0]        mag_s4 [3];
	logic [2:0]           neg_s4;

	// stage 5: per-group leading one
	logic                 v_s5;
	logic [DW-1:0]        mag_s5 [3];
	logic [2:0]           neg_s5;
	logic [3:0]           glen_s5 [NG];
	logic [3:0]           glen_c [NG];
	logic [NG-1:0]        gnz_s5;
	logic [NG*8-1:0]      orm;

	// stage 6: bit length
	logic                 v_s6;
	logic [DW-1:0]        mag_s6 [3];
	logic [2:0]           neg_s6;
	logic [LW-1:0]        maxlen_s6, maxlen_c;

	// stage 7: scaled magnitudes
	logic                 v_s7;
	tun_pass_t            pass_s7;

	// stage 8: squares
	logic                 v_s8;
	logic [2*M_BITS-1:0]  sq_s8 [3];
	tun_pass_t            pass_s8;

	// stage 9: sum of squares
	logic                 v_s9;
	logic [S_BITS-1:0]    sum_s9;
	tun_pass_t            pass_s9;

	logic                 rt_valid;
	logic [R_BITS-1:0]    rt_root;
	tun_pass_t            rt_pass;

	// stage 10: dividend and divisor
	logic                   v_s10;
	logic [2:0][D_BITS-1:0] rem0_s10;
	logic [2:0][QW-1:0]     lo_s10;
	logic [D_BITS-1:0]      dvsr_s10;
	tun_flags_t             flg_s10;

	logic                   dv_valid;
	logic [2:0][QW-1:0]     dv_q;
	tun_flags_t             dv_flags;

	logic                     out_valid_q;
	logic signed [OUT_BITS-1:0] nrm_q [3];
	logic                     deg_q;

	assign en         = !out_valid_q || norm.ready;
	assign vert.ready = en;

	assign va = '{vert.v0_x, vert.v0_y, vert.v0_z};
	assign vb = '{vert.v1_x, vert.v1_y, vert.v1_z};
	assign vc = '{vert.v2_x, vert.v2_y, vert.v2_z};

	always_comb begin
		orm = (NG*8)'(mag_s4[0] | mag_s4[1] | mag_s4[2]);
	end

	// bit length within each group of eight
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			glen_c[g] = '0;
			for (int b = 0; b < 8; b++) begin
				if (orm[g*8+b]) begin
					glen_c[g] = 4'(b + 1);
				end
			end
		end
	end

	always_comb begin
		maxlen_c = '0;
		for (int g = 0; g < NG; g++) begin
			if (gnz_s5[g]) begin
				maxlen_c = LW'(g * 8) + LW'(glen_s5[g]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			v_s8        <= 1'b0;
			v_s9        <= 1'b0;
			v_s10       <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= vert.valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			v_s8        <= v_s7;
			v_s9        <= v_s8;
			v_s10       <= rt_valid;
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= EW'(vb[i]) - EW'(va[i]);
				e2_s1[i] <= EW'(vc[i]) - EW'(va[i]);
			end

			p_s2[0] <= PW'(e1_s1[1]) * PW'(e2_s1[2]);
			q_s2[0] <= PW'(e2_s1[1]) * PW'(e1_s1[2]);
			p_s2[1] <= PW'(e1_s1[2]) * PW'(e2_s1[0]);
			q_s2[1] <= PW'(e2_s1[2]) * PW'(e1_s1[0]);
			p_s2[2] <= PW'(e1_s1[0]) * PW'(e2_s1[1]);
			q_s2[2] <= PW'(e2_s1[0]) * PW'(e1_s1[1]);

			for (int i = 0; i < 3; i++) begin
				c_s3[i]   <= DW'(p_s2[i]) - DW'(q_s2[i]);
				mag_s4[i] <= c_s3[i][DW-1] ? DW'(-c_s3[i]) : DW'(c_s3[i]);
				neg_s4[i] <= c_s3[i][DW-1];
			end

			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
			glen_s5 <= glen_c;
			for (int g = 0; g < NG; g++) begin
				gnz_s5[g] <= |orm[g*8 +: 8];
			end

			mag_s6    <= mag_s5;
			neg_s6    <= neg_s5;
			maxlen_s6 <= maxlen_c;

			// bring the largest magnitude into [2^29, 2^30), dropping low bits when it is wider
			for (int i = 0; i < 3; i++) begin
				pass_s7.m[i] <= M_BITS'({mag_s6[i], M_BITS'(0)} >> maxlen_s6);
			end
			pass_s7.neg <= neg_s6;
			pass_s7.deg <= maxlen_s6 == '0;

			for (int i = 0; i < 3; i++) begin
				sq_s8[i] <= (2*M_BITS)'(pass_s7.m[i]) * (2*M_BITS)'(pass_s7.m[i]);
			end
			pass_s8 <= pass_s7;

			sum_s9  <= S_BITS'(sq_s8[0]) + S_BITS'(sq_s8[1]) + S_BITS'(sq_s8[2]);
			pass_s9 <= pass_s8;

			// dividend m * 2^(F+1) + L over divisor 2L rounds half away from zero
			for (int i = 0; i < 3; i++) begin
				logic [NW-1:0] num;
				num         = NW'({rt_pass.m[i], QW'(0)}) + NW'(rt_root);
				rem0_s10[i] <= D_BITS'(num >> QW);
				lo_s10[i]   <= num[QW-1:0];
			end
			dvsr_s10    <= {rt_root, 1'b0};
			flg_s10.neg <= rt_pass.neg;
			flg_s10.deg <= rt_pass.deg;

			deg_q <= dv_flags.deg;
			for (int i = 0; i < 3; i++) begin
				logic signed [XW-1:0] sv;
				sv = dv_flags.neg[i] ? -XW'(dv_q[i]) : XW'(dv_q[i]);
				if (dv_flags.deg) begin
					nrm_q[i] <= '0;
				end else if (sv > SAT_HI) begin
					nrm_q[i] <= OUT_BITS'(SAT_HI);
				end else if (sv < SAT_LO) begin
					nrm_q[i] <= OUT_BITS'(SAT_LO);
				end else begin
					nrm_q[i] <= OUT_BITS'(sv);
				end
			end
		end
	end

	tun_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s9),
		.rad      (sum_s9),
		.in_pass  (pass_s9),
		.out_valid(rt_valid),
		.root     (rt_root),
		.out_pass (rt_pass)
	);

	tun_div #(.QW(QW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s10),
		.rem0     (rem0_s10),
		.lo       (lo_s10),
		.dvsr     (dvsr_s10),
		.in_flags (flg_s10),
		.out_valid(dv_valid),
		.quot     (dv_q),
		.out_flags(dv_flags)
	);

	assign norm.valid      = out_valid_q;
	assign norm.normal_x   = nrm_q[0];
	assign norm.normal_y   = nrm_q[1];
	assign norm.normal_z   = nrm_q[2];
	assign norm.degenerate = deg_q;

	`TUN_ASSERT_IMP(a_deg_zero, clk, arst_n, norm.valid && norm.degenerate, norm.normal_x == '0 && norm.normal_y == '0 && norm.normal_z == '0)
	`TUN_ASSERT_IMP(a_stall_blocks_in, clk, arst_n, norm.valid && !norm.ready, !vert.ready)
	`TUN_ASSERT_IMP(a_quot_bound, clk, arst_n, dv_valid && !dv_flags.deg, dv_q[0] <= Q_MAX && dv_q[1] <= Q_MAX && dv_q[2] <= Q_MAX)
	`TUN_ASSERT_NEXT(a_accept_enters, clk, arst_n, vert.valid && vert.ready, v_s1)
endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for the triangle unit normal block: a directed table, then random
// triangles, each checked against its known table entry or a bit-exact normal predictor held in this file.
// Depends on tun_pkg, the tun_in_if/tun_out_if interfaces and the RTL top level.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tun_pkg::*;

	localparam int CB        = COORD_BITS_DEF;
	localparam int FRAC      = NORMAL_FRAC_BITS_DEF;
	localparam int N_RANDOM  = 1000;
	localparam int N_DIR     = 14;
	localparam int CYC_LIMIT = 1000000;
	localparam int C_MAX     = 8388607;
	localparam int C_MIN     = -8388608;

	typedef struct {
		logic signed [OUT_BITS-1:0] nx, ny, nz;
		logic                       deg;
	} normal_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	tun_in_if #(.COORD_BITS(CB)) vert_ch ();
	tun_out_if norm_ch ();

	triangle_unit_normal #(.COORD_BITS(CB), .NORMAL_FRAC_BITS(FRAC)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.vert   (vert_ch),
		.norm   (norm_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// columns: nine coordinates, known flag, normal x/y/z, degenerate
	int dir_tab[N_DIR][14] = '{
		'{0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1},
		'{0, 0, 0, 256, 0, 0, 0, 256, 0, 1, 0, 0, 16384, 0},
		'{0, 0, 0, 0, 256, 0, 256, 0, 0, 1, 0, 0, -16384, 0},
		'{0, 0, 0, 0, 256, 0, 0, 0, 256, 1, 16384, 0, 0, 0},
		'{0, 0, 0, 0, 0, 256, 256, 0, 0, 1, 0, 16384, 0, 0},
		'{1, 2, 3, 2, 4, 6, 3, 6, 9, 1, 0, 0, 0, 1},
		'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 1234, -99, 77, 1, 0, 0, 0, 1},
		'{C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, C_MIN, C_MIN, C_MAX, C_MIN, 1, 0, 0, 16384, 0},
		'{C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, 1, 0, 0, 16384, 0},
		'{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 0, 0, 16384, 0},
		'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, C_MIN, C_MAX, 0, 0, 0, 0, 0},
		'{0, 0, 0, 256, -256, 0, 0, 256, -256, 0, 0, 0, 0, 0},
		'{0, 0, 0, C_MAX, 0, 0, 0, C_MAX, 1, 0, 0, 0, 0, 0},
		'{-1, -1, -1, C_MAX, 3, C_MIN, 5, C_MIN, C_MAX, 0, 0, 0, 0, 0}
	};

	normal_t normals_due[$];
	int      mismatches = 0;
	int      normals_seen = 0;
	int      degenerate_seen = 0;
	int      send_idle = 0;
	int      recv_stall = 0;
	longint  cycles = 0;

	// exact cross product, scale largest magnitude into [2^29, 2^30), root, rounded divide
	function automatic normal_t predict_normal(input int c[9]);
		longint    e1[3], e2[3], cr[3];
		bit [63:0] mg[3], m[3];
		bit [63:0] sum, x, res, bitv, q;
		longint    sv;
		int        ml, sh, b;
		normal_t   r;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'(c[3+i]) - longint'(c[i]);
			e2[i] = longint'(c[6+i]) - longint'(c[i]);
		end
		cr[0] = e1[1] * e2[2] - e2[1] * e1[2];
		cr[1] = e1[2] * e2[0] - e2[2] * e1[0];
		cr[2] = e1[0] * e2[1] - e2[0] * e1[1];
		ml = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = (cr[i] < 0) ? -cr[i] : cr[i];
			b = 0;
			for (int k = 0; k < 64; k++)
				if (mg[i][k]) b = k + 1;
			if (b > ml) ml = b;
		end
		r = '{nx: '0, ny: '0, nz: '0, deg: 1'b1};
		if (ml == 0)
			return r;
		sh = ml - 30;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = (sh > 0) ? (mg[i] >> sh) : (mg[i] << (-sh));
			sum += m[i] * m[i];
		end
		x = sum;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		for (int i = 0; i < 3; i++) begin
			q = ((m[i] << (FRAC + 1)) + res) / (2 * res);
			sv = (cr[i] < 0) ? -longint'(q) : longint'(q);
			if (sv > 32767) sv = 32767;
			if (sv < -32768) sv = -32768;
			case (i)
				0: r.nx = sv[15:0];
				1: r.ny = sv[15:0];
				default: r.nz = sv[15:0];
			endcase
		end
		r.deg = 1'b0;
		return r;
	endfunction

	function automatic int any_coord();
		return int'($signed(24'($urandom())));
	endfunction

	function automatic int edge_coord();
		int pick = $urandom_range(4);
		case (pick)
			0: return C_MIN;
			1: return C_MAX;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// mostly genuine triangles, with flat ones, extremes and raw noise mixed in
	task automatic make_triangle(output int c[9]);
		int kind = $urandom_range(9);
		int d[3], k1, k2;
		for (int i = 0; i < 9; i++) c[i] = any_coord();
		case (kind)
			0, 1, 2: ;
			3, 4, 5: begin
				for (int i = 0; i < 3; i++) begin
					c[i] = $signed($urandom_range(40000)) - 20000;
					c[3+i] = c[i] + $signed($urandom_range(2000)) - 1000;
					c[6+i] = c[i] + $signed($urandom_range(2000)) - 1000;
				end
			end
			6, 7: begin
				k1 = $signed($urandom_range(6)) - 3;
				k2 = $signed($urandom_range(6)) - 3;
				for (int i = 0; i < 3; i++) begin
					c[i] = $signed($urandom_range(200000)) - 100000;
					d[i] = $signed($urandom_range(20000)) - 10000;
					c[3+i] = c[i] + k1 * d[i];
					c[6+i] = c[i] + k2 * d[i];
				end
			end
			8: for (int i = 0; i < 9; i++) c[i] = edge_coord();
			default: begin
				for (int i = 0; i < 3; i++) begin
					c[3+i] = c[i] + $signed($urandom_range(2)) - 1;
					c[6+i] = c[i] + $signed($urandom_range(2)) - 1;
					if (c[i] > 8388605 || c[i] < -8388605) c[i] = 0;
					c[3+i] = c[i] + ((c[3+i] > c[i]) ? 1 : (c[3+i] < c[i]) ? -1 : 0);
					c[6+i] = c[i] + ((c[6+i] > c[i]) ? 1 : (c[6+i] < c[i]) ? -1 : 0);
				end
			end
		endcase
	endtask

	// hold the transaction until the block takes it, then log the expected normal
	task automatic send_triangle(input int c[9], input bit known, input normal_t typed);
		while ($urandom_range(99) < send_idle) begin
			vert_ch.valid <= 1'b0;
			@(posedge clk);
		end
		vert_ch.valid <= 1'b1;
		vert_ch.v0_x <= c[0][CB-1:0];
		vert_ch.v0_y <= c[1][CB-1:0];
		vert_ch.v0_z <= c[2][CB-1:0];
		vert_ch.v1_x <= c[3][CB-1:0];
		vert_ch.v1_y <= c[4][CB-1:0];
		vert_ch.v1_z <= c[5][CB-1:0];
		vert_ch.v2_x <= c[6][CB-1:0];
		vert_ch.v2_y <= c[7][CB-1:0];
		vert_ch.v2_z <= c[8][CB-1:0];
		do @(posedge clk); while (!vert_ch.ready);
		normals_due.insert(normals_due.size(), known ? typed : predict_normal(c));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		normal_t exp_n;
		if (!arst_n) begin
			norm_ch.ready <= 1'b0;
		end else begin
			if (norm_ch.valid && norm_ch.ready) begin
				normals_seen++;
				if (norm_ch.degenerate) degenerate_seen++;
				if (normals_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Unexpected normal (%0d,%0d,%0d) deg %0b", norm_ch.normal_x,
							norm_ch.normal_y, norm_ch.normal_z, norm_ch.degenerate);
				end else begin
					exp_n = normals_due.pop_front();
					if (norm_ch.normal_x !== exp_n.nx || norm_ch.normal_y !== exp_n.ny ||
						norm_ch.normal_z !== exp_n.nz || norm_ch.degenerate !== exp_n.deg) begin
						mismatches++;
						if (mismatches <= 10)
							$display("Normal %0d: expected (%0d,%0d,%0d) deg %0b, got (%0d,%0d,%0d) deg %0b",
								normals_seen, exp_n.nx, exp_n.ny, exp_n.nz, exp_n.deg,
								norm_ch.normal_x, norm_ch.normal_y, norm_ch.normal_z,
								norm_ch.degenerate);
					end
				end
			end
			norm_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	initial begin
		int      c[9];
		normal_t typed;
		int      wait_cycles;
		vert_ch.valid = 1'b0;
		vert_ch.v0_x = '0; vert_ch.v0_y = '0; vert_ch.v0_z = '0;
		vert_ch.v1_x = '0; vert_ch.v1_y = '0; vert_ch.v1_z = '0;
		vert_ch.v2_x = '0; vert_ch.v2_y = '0; vert_ch.v2_z = '0;
		norm_ch.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++) begin
			for (int i = 0; i < 9; i++) c[i] = dir_tab[r][i];
			typed.nx = dir_tab[r][10][15:0];
			typed.ny = dir_tab[r][11][15:0];
			typed.nz = dir_tab[r][12][15:0];
			typed.deg = dir_tab[r][13][0];
			send_triangle(c, dir_tab[r][9] != 0, typed);
		end

		// advance through the idling phases: none, sender, receiver, both
		for (int n = 0; n < N_RANDOM; n++) begin
			case (n * 4 / N_RANDOM)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 87; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 87; end
				default: begin send_idle = 35; recv_stall = 35; end
			endcase
			make_triangle(c);
			send_triangle(c, 1'b0, typed);
		end
		vert_ch.valid <= 1'b0;

		wait_cycles = 0;
		while (normals_due.size() != 0 && wait_cycles < 20000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (80) @(posedge clk);
		$display("Sent %0d triangles (%0d table rows), checked %0d normals, %0d degenerate.",
			N_DIR + N_RANDOM, N_DIR, normals_seen, degenerate_seen);
		$display("Idling phases covered: none, sender 87%%, receiver 87%%, both 35%%.");
		if (mismatches == 0 && normals_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches, %0d normals outstanding", mismatches, normals_due.size());
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tun_pkg.sv
hw/rtl/tun_if.sv
hw/rtl/tun_isqrt.sv
hw/rtl/tun_div.sv
hw/rtl/triangle_unit_normal.sv
tb/testbench.sv
